### design/bpb_pkg.sv
// Shared types and constants of the patch bisection and binning block.
package bpb_pkg;

  localparam int FIELD_W = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int ADDR_W  = 5;
  localparam int REG_W   = 3;

  // commands carried by an input beat
  localparam logic CMD_BUILD    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // register indexes
  localparam logic [REG_W-1:0] REG_X_LO  = 3'd0;
  localparam logic [REG_W-1:0] REG_X_HI  = 3'd1;
  localparam logic [REG_W-1:0] REG_Y_LO  = 3'd2;
  localparam logic [REG_W-1:0] REG_Y_HI  = 3'd3;
  localparam logic [REG_W-1:0] REG_COUNT = 3'd4;

  localparam logic [FIELD_W-1:0] RST_X_LO  = 32'hFFFF_0000;
  localparam logic [FIELD_W-1:0] RST_X_HI  = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] RST_Y_LO  = 32'hFFFF_0000;
  localparam logic [FIELD_W-1:0] RST_Y_HI  = 32'h0001_0000;
  localparam logic [CNT_W-1:0]   RST_COUNT = 7'd1;

  // rectangle sides within a packed rect word
  localparam int SIDE_L = 0;
  localparam int SIDE_R = 1;
  localparam int SIDE_B = 2;
  localparam int SIDE_T = 3;

  // queue operations on the cell row
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_SHIFT = 2'd1;  // shift left, ins_a at size-1
  localparam logic [1:0] CELL_SPLIT = 2'd2;  // as shift, plus ins_b at size

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] size;
    logic [CNT_W-1:0] built;
    logic             advance;
  } cell_ctrl_t;

endpackage

### design/bpb_item_if.sv
// Input channel: command and point coordinates.
interface bpb_item_if;
  import bpb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;

  modport source(output valid, command, point_x, point_y, input ready);
  modport sink(input valid, command, point_x, point_y, output ready);
endinterface

### design/bpb_result_if.sv
// Result channel: patch index, bounds and flags.
interface bpb_result_if;
  import bpb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          patch_index;
  logic signed [FIELD_W-1:0] bound_x_lo;
  logic signed [FIELD_W-1:0] bound_x_hi;
  logic signed [FIELD_W-1:0] bound_y_lo;
  logic signed [FIELD_W-1:0] bound_y_hi;
  logic                      found;
  logic                      last;

  modport source(output valid, patch_index, bound_x_lo, bound_x_hi, bound_y_lo,
                 bound_y_hi, found, last, input ready);
  modport sink(input valid, patch_index, bound_x_lo, bound_x_hi, bound_y_lo,
               bound_y_hi, found, last, output ready);
endinterface

### design/bpb_cell.sv
// One patch cell: queue slot for the build and one stage of the classify chain.
module bpb_cell #(
  parameter int COORD_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bpb_pkg::cell_ctrl_t                  ctrl,
  input  logic [3:0][COORD_WIDTH-1:0]          ins_a,
  input  logic [3:0][COORD_WIDTH-1:0]          ins_b,
  input  logic [3:0][COORD_WIDTH-1:0]          rect_in,
  output logic [3:0][COORD_WIDTH-1:0]          rect,
  input  logic                                 valid_in,
  input  logic signed [COORD_WIDTH-1:0]        x_in,
  input  logic signed [COORD_WIDTH-1:0]        y_in,
  input  logic                                 found_in,
  input  logic [bpb_pkg::IDX_W-1:0]            idx_in,
  input  logic [3:0][COORD_WIDTH-1:0]          bnd_in,
  output logic                                 valid_out,
  output logic signed [COORD_WIDTH-1:0]        x_out,
  output logic signed [COORD_WIDTH-1:0]        y_out,
  output logic                                 found_out,
  output logic [bpb_pkg::IDX_W-1:0]            idx_out,
  output logic [3:0][COORD_WIDTH-1:0]          bnd_out
);
  import bpb_pkg::*;

  localparam logic [CNT_W-1:0] POS     = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(INDEX);

  logic [3:0][COORD_WIDTH-1:0] rect_next;
  logic [CNT_W-1:0]            tail;
  logic                        hit;

  assign tail = ctrl.size - CNT_W'(1);

  always_comb begin
    rect_next = rect;
    case (ctrl.op)
      CELL_SHIFT, CELL_SPLIT: begin
        if (POS == tail) begin
          rect_next = ins_a;
        end else if (ctrl.op == CELL_SPLIT && POS == ctrl.size) begin
          rect_next = ins_b;
        end else if (POS < tail) begin
          rect_next = rect_in;
        end
      end
      default: rect_next = rect;
    endcase
  end

  always_ff @(posedge clk) begin
    rect <= rect_next;
  end

  // half-open containment, only for slots inside the built table
  assign hit = (POS < ctrl.built) &&
               (x_in >= $signed(rect[SIDE_L])) && (x_in < $signed(rect[SIDE_R])) &&
               (y_in >= $signed(rect[SIDE_B])) && (y_in < $signed(rect[SIDE_T]));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctrl.advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      x_out <= x_in;
      y_out <= y_in;
      if (!found_in && hit) begin
        found_out <= 1'b1;
        idx_out   <= POS_IDX;
        bnd_out   <= rect;
      end else begin
        found_out <= found_in;
        idx_out   <= idx_in;
        bnd_out   <= bnd_in;
      end
    end
  end

endmodule

### design/bisection_patch_partition_and_binning.sv
// Top level: recursive bisection of a domain into patches and point binning.
//
// The patch table lives in a row of MAX_PATCHES cells, one rectangle each.
// During a build the row acts as the bisection queue: every split cycle pops
// the head cell, shifts the row left and writes the two halves at the tail.
// A build loads the domain into the head cell, splits until the queue holds
// the saturated patch count, latches the table size, then emits a beat per
// patch, one per cycle while the result register is free, rotating the row
// back into queue order. No input is taken while a build runs. A classify
// beat travels down the row as a systolic chain, one cell per cycle, picking
// up the first matching patch; classifies enter one per cycle, and each
// result passes every cell and then the result register, with the whole chain
// frozen while that register is stalled. A build beat is taken only once the
// chain has drained, so results always leave in input order. Coordinates are
// held internally at COORD_WIDTH bits; the 32-bit fields are taken in and
// given out by their low bits (zero filled where the receiving word is wider).
// Configuration is an APB slave, registers at 4*index, always ready.
module bisection_patch_partition_and_binning #(
  parameter int MAX_PATCHES = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  bpb_item_if.sink                     item,
  bpb_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpb_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpb_pkg::FIELD_W-1:0]  pwdata,
  output logic [bpb_pkg::FIELD_W-1:0]  prdata,
  output logic                         pready
);
  import bpb_pkg::*;

  localparam int WIDE = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATCHES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  typedef logic [3:0][COORD_WIDTH-1:0] rect_t;

  // field to internal coordinate: low bits, zero filled above the field
  function automatic logic [COORD_WIDTH-1:0] to_coord(input logic [FIELD_W-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    return w[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [COORD_WIDTH-1:0] c);
    logic [WIDE-1:0] w;
    w = WIDE'(c);
    return w[FIELD_W-1:0];
  endfunction

  // floor((a + b) / 2) with one guard bit, so it cannot overflow
  function automatic logic [COORD_WIDTH-1:0] midpoint(input logic [COORD_WIDTH-1:0] a,
                                                      input logic [COORD_WIDTH-1:0] b);
    logic [COORD_WIDTH:0] sum;
    sum = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
    return sum[COORD_WIDTH:1];
  endfunction

  // ---------------- configuration ----------------
  logic [FIELD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [CNT_W-1:0]   patch_count;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lo        <= RST_X_LO;
      x_hi        <= RST_X_HI;
      y_lo        <= RST_Y_LO;
      y_hi        <= RST_Y_HI;
      patch_count <= RST_COUNT;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_X_LO:  x_lo <= pwdata;
        REG_X_HI:  x_hi <= pwdata;
        REG_Y_LO:  y_lo <= pwdata;
        REG_Y_HI:  y_hi <= pwdata;
        REG_COUNT: patch_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_X_LO:  prdata = x_lo;
      REG_X_HI:  prdata = x_hi;
      REG_Y_LO:  prdata = y_lo;
      REG_Y_HI:  prdata = y_hi;
      REG_COUNT: prdata = FIELD_W'(patch_count);
      default:   prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] size, size_next;      // queue occupancy
  logic [CNT_W-1:0] target, target_next;  // saturated patch count
  logic [CNT_W-1:0] left, left_next;      // splits left in this pass
  logic             pass_odd, pass_odd_next;
  logic [IDX_W-1:0] emit_i, emit_i_next;
  logic [CNT_W-1:0] built, built_next;

  // output register
  logic             out_valid;
  logic [IDX_W-1:0] out_idx;
  logic [FIELD_W-1:0] out_xl, out_xh, out_yl, out_yh;
  logic             out_found, out_last;

  logic             adv;          // result register free to take a beat
  logic             chain_busy;
  logic             take, take_build, take_cls;
  logic [CNT_W-1:0] sat_count;
  logic             emit_fire, emit_last;

  // cell row and classify chain
  rect_t            cell_rect [MAX_PATCHES];
  rect_t            ins_a, ins_b, head, domain;
  cell_ctrl_t       ctrl;

  logic [MAX_PATCHES:0]          c_valid;
  logic [COORD_WIDTH-1:0]        c_x     [MAX_PATCHES+1];
  logic [COORD_WIDTH-1:0]        c_y     [MAX_PATCHES+1];
  logic                          c_found [MAX_PATCHES+1];
  logic [IDX_W-1:0]              c_idx   [MAX_PATCHES+1];
  rect_t                         c_bnd   [MAX_PATCHES+1];

  logic             cur_odd;
  logic [CNT_W-1:0] cur_left;
  logic [COORD_WIDTH-1:0] mid;

  assign adv        = !out_valid || result.ready;
  assign chain_busy = |c_valid[MAX_PATCHES:1];
  assign head       = cell_rect[0];

  assign item.ready = (state == ST_IDLE) && adv &&
                      (item.command == CMD_CLASSIFY || !chain_busy);
  assign take       = item.valid && item.ready;
  assign take_build = take && item.command == CMD_BUILD;
  assign take_cls   = take && item.command == CMD_CLASSIFY;

  // zero means one, anything above the row length saturates
  always_comb begin
    if (patch_count == '0) begin
      sat_count = CNT_W'(1);
    end else if (patch_count > MAX_CNT) begin
      sat_count = MAX_CNT;
    end else begin
      sat_count = patch_count;
    end
  end

  assign domain[SIDE_L] = to_coord(x_lo);
  assign domain[SIDE_R] = to_coord(x_hi);
  assign domain[SIDE_B] = to_coord(y_lo);
  assign domain[SIDE_T] = to_coord(y_hi);

  // a new pass starts when the previous one has used up its rectangles
  always_comb begin
    if (left == '0) begin
      cur_odd  = !pass_odd;
      cur_left = size;
    end else begin
      cur_odd  = pass_odd;
      cur_left = left;
    end
  end

  assign mid = cur_odd ? midpoint(head[SIDE_B], head[SIDE_T])
                       : midpoint(head[SIDE_L], head[SIDE_R]);

  assign emit_fire = (state == ST_EMIT) && adv;
  assign emit_last = (CNT_W'(emit_i) + CNT_W'(1)) == size;

  always_comb begin
    state_next    = state;
    size_next     = size;
    target_next   = target;
    left_next     = left;
    pass_odd_next = pass_odd;
    emit_i_next   = emit_i;
    built_next    = built;
    ctrl.op       = CELL_HOLD;
    ctrl.size     = size;
    ctrl.built    = built;
    ctrl.advance  = adv;
    ins_a         = head;
    ins_b         = head;
    case (state)
      ST_IDLE: begin
        if (take_build) begin
          // seed the queue with the domain in the head cell
          ctrl.op       = CELL_SHIFT;
          ctrl.size     = CNT_W'(1);
          ins_a         = domain;
          size_next     = CNT_W'(1);
          target_next   = sat_count;
          left_next     = CNT_W'(1);
          pass_odd_next = 1'b0;
          state_next    = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (size == target) begin
          built_next  = size;
          emit_i_next = '0;
          state_next  = ST_EMIT;
        end else begin
          ctrl.op = CELL_SPLIT;
          if (cur_odd) begin
            ins_a[SIDE_T] = mid;
            ins_b[SIDE_B] = mid;
          end else begin
            ins_a[SIDE_R] = mid;
            ins_b[SIDE_L] = mid;
          end
          pass_odd_next = cur_odd;
          left_next     = cur_left - CNT_W'(1);
          size_next     = size + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (adv) begin
          // rotate: head goes to the tail, row order is restored after size beats
          ctrl.op     = CELL_SHIFT;
          emit_i_next = emit_i + IDX_W'(1);
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      built <= '0;
    end else begin
      state <= state_next;
      built <= built_next;
    end
  end

  always_ff @(posedge clk) begin
    size     <= size_next;
    target   <= target_next;
    left     <= left_next;
    pass_odd <= pass_odd_next;
    emit_i   <= emit_i_next;
  end

  // ---------------- cell row ----------------
  assign c_valid[0] = take_cls;
  assign c_x[0]     = to_coord(item.point_x);
  assign c_y[0]     = to_coord(item.point_y);
  assign c_found[0] = 1'b0;
  assign c_idx[0]   = '0;
  assign c_bnd[0]   = '0;

  for (genvar i = 0; i < MAX_PATCHES; i++) begin : g_cell
    rect_t nb;
    if (i == MAX_PATCHES - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_rect[i+1];
    end

    bpb_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .ins_a    (ins_a),
      .ins_b    (ins_b),
      .rect_in  (nb),
      .rect     (cell_rect[i]),
      .valid_in (c_valid[i]),
      .x_in     (c_x[i]),
      .y_in     (c_y[i]),
      .found_in (c_found[i]),
      .idx_in   (c_idx[i]),
      .bnd_in   (c_bnd[i]),
      .valid_out(c_valid[i+1]),
      .x_out    (c_x[i+1]),
      .y_out    (c_y[i+1]),
      .found_out(c_found[i+1]),
      .idx_out  (c_idx[i+1]),
      .bnd_out  (c_bnd[i+1])
    );
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit_fire || c_valid[MAX_PATCHES];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_idx   <= emit_i;
      out_xl    <= to_field(head[SIDE_L]);
      out_xh    <= to_field(head[SIDE_R]);
      out_yl    <= to_field(head[SIDE_B]);
      out_yh    <= to_field(head[SIDE_T]);
      out_found <= 1'b1;
      out_last  <= emit_last;
    end else if (adv && c_valid[MAX_PATCHES]) begin
      out_idx   <= c_idx[MAX_PATCHES];
      out_xl    <= to_field(c_bnd[MAX_PATCHES][SIDE_L]);
      out_xh    <= to_field(c_bnd[MAX_PATCHES][SIDE_R]);
      out_yl    <= to_field(c_bnd[MAX_PATCHES][SIDE_B]);
      out_yh    <= to_field(c_bnd[MAX_PATCHES][SIDE_T]);
      out_found <= c_found[MAX_PATCHES];
      out_last  <= 1'b1;
    end
  end

  assign result.valid       = out_valid;
  assign result.patch_index = out_idx;
  assign result.bound_x_lo  = out_xl;
  assign result.bound_x_hi  = out_xh;
  assign result.bound_y_lo  = out_yl;
  assign result.bound_y_hi  = out_yh;
  assign result.found       = out_found;
  assign result.last        = out_last;

endmodule
